/* rtl/hlgp_pkg.sv */
// Shared types, constants and the gamma threshold table of the HDR to LDR pack core.
package hlgp_pkg;

  localparam int unsigned ACC_W   = 32;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned PROD_W  = ACC_W + SCALE_W;
  localparam int unsigned FRAC_SH = 24;
  localparam int unsigned Q_W     = 17;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned NUM_STG = CODE_W + 1;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned BIG_W   = 192;

  localparam logic [CODE_W-1:0] ALPHA_CODE = 8'hFF;
  localparam logic [Q_W-1:0]    Q_SAT      = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORM_SCALE  = 8'd0,
    REG_IMAGE_READY = 8'd1
  } cfg_reg_e;

  typedef logic [NUM_STG-1:0] stg_vec_t;
  typedef logic [(1 << CODE_W)-1:0][Q_W-1:0] thr_t;

  // Entry c is the smallest q with q^5 * 255^11 >= c^11 * 2^80, which is
  // ceil(65536 * (c/255)^2.2) computed exactly with wide integers.
  function automatic thr_t gen_thr();
    thr_t             t;
    logic [BIG_W-1:0] k255;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] lhs;
    logic [Q_W:0]     lo;
    logic [Q_W:0]     hi;
    logic [Q_W:0]     mid;
    k255 = BIG_W'(1);
    for (int i = 0; i < 11; i++) begin
      k255 = k255 * BIG_W'(255);
    end
    for (int c = 0; c < (1 << CODE_W); c++) begin
      rhs = BIG_W'(1);
      for (int i = 0; i < 11; i++) begin
        rhs = rhs * BIG_W'(c);
      end
      rhs = rhs << 80;
      lo = '0;
      hi = (Q_W + 1)'(Q_SAT);
      for (int it = 0; it < Q_W + 1; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          lhs = k255;
          for (int i = 0; i < 5; i++) begin
            lhs = lhs * BIG_W'(mid);
          end
          if (lhs >= rhs) begin
            hi = mid;
          end else begin
            lo = mid + (Q_W + 1)'(1);
          end
        end
      end
      t[c] = lo[Q_W-1:0];
    end
    return t;
  endfunction

  localparam thr_t THR = gen_thr();

endpackage

/* rtl/hlgp_chan_pipe.sv */
// Datapath of one color channel: scale multiply followed by an eight-stage bisection.
module hlgp_chan_pipe (
  input  logic                            clk_i,
  input  hlgp_pkg::stg_vec_t              ld_i,
  input  logic [hlgp_pkg::ACC_W-1:0]      acc_i,
  input  logic [hlgp_pkg::SCALE_W-1:0]    scale_i,
  output logic [hlgp_pkg::CODE_W-1:0]     code_o
);
  import hlgp_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic [Q_W-1:0]    q_first;
  logic [Q_W-1:0]    q_q    [CODE_W-1];
  logic [CODE_W-1:0] code_q [CODE_W];

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      prod_q <= PROD_W'(acc_i) * PROD_W'(scale_i);
    end
  end

  // Anything at or above 1.0 after normalizing saturates; the top table
  // entry equals the saturated value, so the search then lands on 255.
  assign q_first = (|prod_q[PROD_W-1:FRAC_SH+16]) ? Q_SAT
                                                   : {1'b0, prod_q[FRAC_SH+15:FRAC_SH]};

  for (genvar k = 0; k < CODE_W; k++) begin : g_step
    logic [Q_W-1:0]    q_cur;
    logic [CODE_W-1:0] prev;
    logic [CODE_W-1:0] cand;
    logic [CODE_W-1:0] code_d;

    if (k == 0) begin : g_head
      assign q_cur = q_first;
      assign prev  = '0;
    end else begin : g_body
      assign q_cur = q_q[k-1];
      assign prev  = code_q[k-1];
    end

    assign cand   = prev | (CODE_W'(1) << (CODE_W - 1 - k));
    assign code_d = (q_cur >= THR[cand]) ? cand : prev;

    always_ff @(posedge clk_i) begin
      if (ld_i[k+1]) begin
        code_q[k] <= code_d;
      end
    end

    if (k < CODE_W - 1) begin : g_qreg
      always_ff @(posedge clk_i) begin
        if (ld_i[k+1]) begin
          q_q[k] <= q_cur;
        end
      end
    end
  end

  assign code_o = code_q[CODE_W-1];

endmodule

/* rtl/hdr_to_ldr_gamma_pack_core.sv */
// Top level of the HDR to LDR gamma 2.2 tone map and RGBA8 pack core.
//
// This core turns one accumulated HDR pixel per transaction (red, green and
// blue, each unsigned Q16.16) into one packed RGBA8 word. Every channel is
// multiplied by norm_scale (unsigned Q8.24, normally one over the samples per
// pixel), truncated to a Q0.16 value and mapped through an exact inverse
// gamma 2.2 curve with truncation; values of 1.0 or more give 255. Alpha is
// always 255. Throughput is one pixel per clock cycle when the output side
// keeps up. The pipeline holds the 32x32 scale multiply stage followed by
// bisection stages against a constant 256-entry threshold table, one code
// bit per stage, the last of which is the output register. Each stage has
// its own valid bit and only stalls when its successor is full, so bubbles
// are squeezed out and input is still taken while a result waits.
// While image_ready is 0, input transactions are accepted and dropped with
// no result. Configuration must only be written while the pipeline is empty.
module hdr_to_ldr_gamma_pack_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hlgp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  // Pixel input. tdata: acc_red [31:0], acc_green [63:32], acc_blue [95:64].
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [95:0]                        s_axis_tdata,
  input  logic                               s_axis_tlast,
  // Pixel output. tdata: packed_pixel [31:0].
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [31:0]                        m_axis_tdata,
  output logic                               m_axis_tlast
);
  import hlgp_pkg::*;

  localparam int unsigned NUM_CH = 3;

  logic [SCALE_W-1:0] norm_scale_q;
  logic               image_ready_q;

  stg_vec_t     valid_q;
  stg_vec_t     last_q;
  stg_vec_t     ld;
  logic [NUM_STG:0] rdy;
  logic [CODE_W-1:0] code [NUM_CH];

  // Configuration registers. Writes to an unknown index are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_scale_q  <= 32'h0100_0000;
      image_ready_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_NORM_SCALE:  norm_scale_q  <= cfg_data_i;
        REG_IMAGE_READY: image_ready_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when its contents move on in the
  // same cycle. The chain runs from the output back to the input.
  assign rdy[NUM_STG] = m_axis_tready;
  for (genvar k = 0; k < NUM_STG; k++) begin : g_rdy
    assign rdy[k] = !valid_q[k] || rdy[k+1];
    assign ld[k]  = rdy[k];
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ld[0]) begin
        valid_q[0] <= s_axis_tvalid && image_ready_q;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (ld[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      last_q[0] <= s_axis_tlast;
    end
    for (int k = 1; k < NUM_STG; k++) begin
      if (ld[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    hlgp_chan_pipe u_chan (
      .clk_i   (clk_i),
      .ld_i    (ld),
      .acc_i   (s_axis_tdata[ch*ACC_W +: ACC_W]),
      .scale_i (norm_scale_q),
      .code_o  (code[ch])
    );
  end

  assign m_axis_tvalid = valid_q[NUM_STG-1];
  assign m_axis_tdata  = {ALPHA_CODE, code[2], code[1], code[0]};
  assign m_axis_tlast  = last_q[NUM_STG-1];

  // Input backpressure only occurs when every stage holds a pixel.
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&valid_q))
    else $error("input stalled while the pipeline has a bubble");

  // A pixel accepted while the image is ready occupies the first stage next.
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && image_ready_q) |=> valid_q[0])
    else $error("accepted pixel did not enter the pipeline");

  // A dropped pixel never creates a result in the first stage.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && !(s_axis_tvalid && image_ready_q)) |=> !valid_q[0])
    else $error("pixel entered the pipeline while it should be dropped");

  // An image_ready write takes effect in the following cycle.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == REG_IMAGE_READY)
      |=> image_ready_q == $past(cfg_data_i[0]))
    else $error("image_ready write lost");

endmodule

/* tb/tb_hdr_to_ldr_gamma_pack_core.sv */
// Self-checking testbench of the HDR to LDR gamma 2.2 tone map and RGBA8 pack core.
module tb_hdr_to_ldr_gamma_pack_core;
  import hlgp_pkg::*;

  // Cycles allowed after the last expected result before the pipeline counts as
  // empty. The core has nine stages, so this is kept well above that depth.
  localparam int unsigned DRAIN_TAIL = 24;
  // Hard stop for a run that hangs.
  localparam int unsigned RUN_LIMIT = 3_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(2);
  localparam logic [31:0]          SCALE_ONE    = 32'h0100_0000;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE, RX_ALTERNATE} rx_mode_e;

  // One line of the directed table: either a pixel transaction or a register
  // write. A pixel row with known set carries a result that can be read off
  // by hand; every other pixel row is checked against the predictor.
  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [31:0]            value;
    logic [31:0]            red;
    logic [31:0]            green;
    logic [31:0]            blue;
    logic                   last;
    logic                   known;
    logic [31:0]            rgba;
  } stim_row_t;

  typedef struct {
    logic [31:0] rgba;
    logic        last;
  } ldr_pixel_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [31:0]          cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic [95:0]          s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_ready_o;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [31:0]          m_axis_tdata;
  logic                 m_axis_tlast;

  // Copy of the configuration as the core should hold it.
  logic [31:0]          scale_shadow = SCALE_ONE;
  logic                 ready_shadow = 1'b0;

  // Results owed by the core, oldest first.
  ldr_pixel_t           pending_pixels[$];
  int unsigned          mismatches = 0;
  int unsigned          burst_left = 0;

  int unsigned          rx_left   = 0;
  rx_mode_e             rx_mode   = RX_OPEN;
  logic                 rx_toggle = 1'b0;

  hdr_to_ldr_gamma_pack_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Inverse gamma 2.2 of one channel. The scaled value q is in units of 2^-16,
  // and the code is the largest c with q^5 * 255^11 >= c^11 * 2^80, which is
  // the same as q >= 65536 * (c/255)^2.2 without any rounding. Both sides stay
  // below 2^168, so 192-bit vectors hold them exactly.
  function automatic logic [7:0] gamma_code(logic [31:0] acc, logic [31:0] scale);
    logic [63:0]  prod;
    logic [39:0]  q;
    logic [191:0] lin_pow;
    logic [191:0] code_pow;
    int           lo;
    int           hi;
    int           mid;
    prod = {32'd0, acc} * {32'd0, scale};
    q    = prod[63:24];
    if (q >= 40'd65536) begin
      return 8'hFF;
    end
    lin_pow = 192'd1;
    for (int i = 0; i < 5; i++) begin
      lin_pow = lin_pow * {152'd0, q};
    end
    for (int i = 0; i < 11; i++) begin
      lin_pow = lin_pow * 192'd255;
    end
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid      = (lo + hi + 1) / 2;
      code_pow = 192'd1;
      for (int i = 0; i < 11; i++) begin
        code_pow = code_pow * 192'(mid);
      end
      code_pow = code_pow << 80;
      if (code_pow <= lin_pow) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo[7:0];
  endfunction

  function automatic stim_row_t pixel_row(logic [31:0] red, logic [31:0] green,
                                          logic [31:0] blue, logic last,
                                          logic known, logic [31:0] rgba);
    stim_row_t row;
    row       = '{kind: ROW_PIXEL, default: '0};
    row.red   = red;
    row.green = green;
    row.blue  = blue;
    row.last  = last;
    row.known = known;
    row.rgba  = rgba;
    return row;
  endfunction

  function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] index, logic [31:0] value);
    stim_row_t row;
    row       = '{kind: ROW_WRITE, default: '0};
    row.index = index;
    row.value = value;
    return row;
  endfunction

  // Radiance values for the random part. Fully random words mostly saturate,
  // so the rest come from small fixed ranges or from a range that reaches just
  // past 1.0 for the current scale, and the whole curve gets exercised.
  function automatic logic [31:0] random_radiance(logic [31:0] scale);
    logic [63:0] span;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 255);
      2: return $urandom_range(0, 32'h0001_FFFF);
      default: begin
        if (scale == 32'd0) begin
          span = 64'hFFFF_FFFF;
        end else begin
          span = (64'd1 << 40) / {32'd0, scale} + 64'd2;
        end
        if (span > 64'hFFFF_FFFF) begin
          span = 64'hFFFF_FFFF;
        end
        return $urandom_range(0, span[31:0]);
      end
    endcase
  endfunction

  // Offers one pixel on the input stream. Pixels go out in bursts; before a
  // new burst the sender may sit idle. While the image is ready, the expected
  // result is queued at the moment the transaction is accepted.
  task automatic send_pixel(input logic [31:0] red, input logic [31:0] green,
                            input logic [31:0] blue, input logic last,
                            input logic known, input logic [31:0] rgba);
    ldr_pixel_t want;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    if (ready_shadow) begin
      if (known) begin
        want.rgba = rgba;
      end else begin
        want.rgba = {ALPHA_CODE, gamma_code(blue, scale_shadow),
                     gamma_code(green, scale_shadow), gamma_code(red, scale_shadow)};
      end
      want.last = last;
      pending_pixels = {pending_pixels, want};
    end
  endtask

  // Stops the sender and waits until every owed result has come out, then
  // lets the pipeline run empty.
  task automatic drain_pipeline();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  // Register writes only happen with the pipeline empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
    drain_pipeline();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    if (index == REG_NORM_SCALE) begin
      scale_shadow = value;
    end else if (index == REG_IMAGE_READY) begin
      ready_shadow = value[0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // The receiver switches between stretches of full speed, random stalls,
  // heavy back-pressure and strict alternation.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 80);
    end
    rx_left--;
    rx_toggle = ~rx_toggle;
    case (rx_mode)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_COIN:  m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_CHOKE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:  m_axis_tready <= rx_toggle;
    endcase
  end

  // Every output transaction is matched against the oldest owed result.
  always @(posedge clk_i) begin : check_results
    ldr_pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected output transaction: packed_pixel %08h, span_last_out %0b",
               m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata !== want.rgba) begin
          $error("packed_pixel: expected %08h, actual %08h", want.rgba, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("span_last_out: expected %0b, actual %0b", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   dir_rows[$];
    logic [31:0] scale;
    logic [31:0] junk;
    int unsigned count;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Right after reset the image is not ready, so the first
    // two pixels must vanish. The hand-written results follow from a scale of
    // one (q equals the radiance), a zero scale, and saturation.
    dir_rows = {dir_rows, pixel_row(32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0)};
    dir_rows = {dir_rows, pixel_row('1, '1, '1, 1'b1, 1'b0, 32'h0)};
    dir_rows = {dir_rows, write_row(REG_IMAGE_READY, 32'd1)};
    dir_rows = {dir_rows, pixel_row(32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 32'hFF00_0000)};
    dir_rows = {dir_rows, pixel_row('1, '1, '1, 1'b1, 1'b1, 32'hFFFF_FFFF)};
    dir_rows = {dir_rows, pixel_row(32'hFFFF, 32'hFFFF, 32'hFFFF, 1'b0, 1'b1,
                                    32'hFFFE_FEFE)};
    dir_rows = {dir_rows, pixel_row(32'h1, 32'h1, 32'h1, 1'b1, 1'b1, 32'hFF01_0101)};
    dir_rows = {dir_rows, pixel_row(32'h1_0000, 32'h0, 32'hFFFF, 1'b0, 1'b1,
                                    32'hFFFE_00FF)};
    dir_rows = {dir_rows, pixel_row(32'h8000, 32'h4000, 32'hC000, 1'b1, 1'b0, 32'h0)};
    dir_rows = {dir_rows, pixel_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFE, 1'b0, 1'b0,
                                    32'h0)};
    // A zero scale crushes every channel to black.
    dir_rows = {dir_rows, write_row(REG_NORM_SCALE, 32'h0)};
    dir_rows = {dir_rows, pixel_row('1, 32'h1234_5678, 32'h1, 1'b1, 1'b1, 32'hFF00_0000)};
    // The largest scale: huge products have to saturate and never wrap.
    dir_rows = {dir_rows, write_row(REG_NORM_SCALE, '1)};
    dir_rows = {dir_rows, pixel_row('1, '1, '1, 1'b0, 1'b1, 32'hFFFF_FFFF)};
    dir_rows = {dir_rows, pixel_row(32'h1, 32'h100, 32'h0, 1'b1, 1'b0, 32'h0)};
    dir_rows = {dir_rows, write_row(REG_NORM_SCALE, 32'h0010_0000)};
    dir_rows = {dir_rows, pixel_row(32'h000F_FFFF, 32'h0010_0000, 32'h0008_0000, 1'b0,
                                    1'b0, 32'h0)};
    // A write to an index with no register behind it must change nothing.
    dir_rows = {dir_rows, write_row(REG_UNMAPPED, '1)};
    dir_rows = {dir_rows, pixel_row(32'h0020_0000, 32'h0, 32'h0007_FFFF, 1'b1, 1'b0,
                                    32'h0)};
    dir_rows = {dir_rows, write_row(REG_IMAGE_READY, 32'd0)};
    dir_rows = {dir_rows, pixel_row(32'h1234_5678, 32'h0000_8000, '1, 1'b1, 1'b0, 32'h0)};
    dir_rows = {dir_rows, write_row(REG_IMAGE_READY, 32'd1)};
    dir_rows = {dir_rows, write_row(REG_NORM_SCALE, SCALE_ONE)};
    dir_rows = {dir_rows, pixel_row(32'h2, 32'h3, 32'h4, 1'b0, 1'b0, 32'h0)};

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_reg(dir_rows[i].index, dir_rows[i].value);
      end else begin
        send_pixel(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                   dir_rows[i].last, dir_rows[i].known, dir_rows[i].rgba);
      end
    end

    // Random part, in phases with a fresh configuration each. The first three
    // phases pin the scale to its extremes and to one; the fourth runs with
    // the image not ready and stays short, since its pixels are only dropped.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: scale = '1;
        1: scale = 32'h0;
        2: scale = SCALE_ONE;
        default: begin
          case ($urandom_range(0, 2))
            0: scale = $urandom;
            1: scale = SCALE_ONE / $urandom_range(1, 4096);
            default: scale = SCALE_ONE * $urandom_range(1, 255);
          endcase
        end
      endcase
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
      end
      write_reg(REG_NORM_SCALE, scale);
      // Only bit 0 of image_ready matters; the other data bits carry junk.
      junk = $urandom;
      write_reg(REG_IMAGE_READY, {junk[31:1], (ph != 3)});
      count = (ph == 3) ? 12 : 50;
      repeat (count) begin
        if ($urandom_range(0, 79) == 0) begin
          drain_pipeline();
        end
        send_pixel(random_radiance(scale_shadow), random_radiance(scale_shadow),
                   random_radiance(scale_shadow), 1'($urandom_range(0, 1)), 1'b0, 32'h0);
      end
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
